// ----- rtl/rcfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types, register indexes and gate constants of the frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int unsigned CHAN_W    = 11;
  localparam int unsigned OFS_W     = 12;
  localparam int unsigned GATE_W    = 7;
  localparam int unsigned HEAD_LEN  = 6;
  localparam int unsigned CHECK_END = 12;
  localparam int unsigned NUM_CHAN  = 4;
  localparam int unsigned REG_IDX_W = 2;

  // register indexes of the config port
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LOW   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_HIGH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_VALUE = 2'd2;

  localparam logic [CHAN_W-1:0] WINDOW_LOW_RST   = 11'd300;
  localparam logic [CHAN_W-1:0] WINDOW_HIGH_RST  = 11'd1700;
  localparam logic [CHAN_W-1:0] CENTER_VALUE_RST = 11'd1024;

  // switch one codes that pick the active gate pair
  localparam logic [1:0] SW_MODE_LOW  = 2'd1;
  localparam logic [1:0] SW_MODE_HIGH = 2'd3;

  localparam logic [GATE_W-1:0] GATE_A_ON   = 7'd60;
  localparam logic [GATE_W-1:0] GATE_A_OFF  = 7'd49;
  localparam logic [GATE_W-1:0] GATE_B_LOW  = 7'd68;
  localparam logic [GATE_W-1:0] GATE_B_HIGH = 7'd75;
  localparam logic [GATE_W-1:0] GATE_B_OFF  = 7'd0;

  typedef struct packed {
    logic [CHAN_W-1:0] window_low;
    logic [CHAN_W-1:0] window_high;
    logic [CHAN_W-1:0] center_value;
  } cfg_t;

  typedef struct packed {
    logic [GATE_W-1:0] gate_b;
    logic [GATE_W-1:0] gate_a;
  } gates_t;

  function automatic gates_t gates_for(input logic [1:0] sw);
    gates_t g;
    case (sw)
      SW_MODE_LOW: begin
        g.gate_a = GATE_A_ON;
        g.gate_b = GATE_B_LOW;
      end
      SW_MODE_HIGH: begin
        g.gate_a = GATE_A_ON;
        g.gate_b = GATE_B_HIGH;
      end
      default: begin
        g.gate_a = GATE_A_OFF;
        g.gate_b = GATE_B_OFF;
      end
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/rcfd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_if
// Handshake channels of the frame decoder: byte in, result out, config write.
// ----------------------------------------------------------------------------
interface rcfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcfd_result_if;
  logic              valid;
  logic              ready;
  logic              frame_valid;
  logic signed [11:0] stick_x;
  logic signed [11:0] stick_y;
  logic signed [11:0] rotation;
  logic signed [11:0] pitch_offset;
  logic [1:0]        switch_one;
  logic [1:0]        switch_two;
  logic [6:0]        gate_a;
  logic [6:0]        gate_b;

  modport source (output valid, output frame_valid, output stick_x, output stick_y,
                  output rotation, output pitch_offset, output switch_one,
                  output switch_two, output gate_a, output gate_b, input ready);
  modport sink   (input valid, input frame_valid, input stick_x, input stick_y,
                  input rotation, input pitch_offset, input switch_one,
                  input switch_two, input gate_a, input gate_b, output ready);
endinterface

interface rcfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rc_frame_channel_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_frame_channel_decoder
// Counts received bytes into fixed-length frames and decodes stick channels.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one received byte per word; words are counted into frames of
//           FRAME_LEN bytes starting at reset, with no sync search.
//   out_o : one result word per completed frame, carrying the frame check
//           (bytes 6 to 11 all zero) and the held channel offsets, switches
//           and PWM gate values.
//   cfg_i : register writes (window low, window high, center), always ready;
//           write them only while no frame is in flight.
// Throughput: one byte per cycle unless a waiting result stalls in_i. The
//   first six bytes shift down a chain of byte cells; four channel lanes
//   check and offset in the cycle the last byte is taken.
// Result: registered, and valid in the cycle after the last byte is taken.
// Reset: byte count, held values and gates clear to zero, the frame check
//   is set and the registers return to 300, 1700 and 1024.
// Stall: while a result waits, in_i is ready only if out_o is being taken
//   in the same cycle.
// ----------------------------------------------------------------------------
module rc_frame_channel_decoder
  import rcfd_pkg::*;
#(
  parameter int unsigned FRAME_LEN = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rcfd_byte_if.sink      in_i,
  rcfd_result_if.source  out_o,
  rcfd_cfg_if.sink       cfg_i
);

  localparam int unsigned CNT_W = $clog2(FRAME_LEN);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

  cfg_t                    cfg_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    check_q;
  logic                    in_fire, last, check_eff, load;
  logic [7:0]              head [HEAD_LEN];
  logic [CHAN_W-1:0]       chan [NUM_CHAN];
  logic signed [OFS_W-1:0] held_next [NUM_CHAN];
  logic [1:0]              sw_one_q, sw_two_q, sw_one_d, sw_two_d;
  gates_t                  gates_q, gates_d;
  logic                    out_valid_q;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low   <= WINDOW_LOW_RST;
      cfg_q.window_high  <= WINDOW_HIGH_RST;
      cfg_q.center_value <= CENTER_VALUE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WINDOW_LOW:   cfg_q.window_low   <= cfg_i.data;
        REG_WINDOW_HIGH:  cfg_q.window_high  <= cfg_i.data;
        REG_CENTER_VALUE: cfg_q.center_value <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- byte counter
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign last       = (cnt_q == LAST_IDX);

  // bytes 6..11 must all be zero, including one arriving as the last byte
  assign check_eff = check_q && !((cnt_q >= CNT_W'(HEAD_LEN)) &&
                                  (cnt_q < CNT_W'(CHECK_END)) &&
                                  (in_i.rx_byte != 8'd0));
  assign load = in_fire && last && check_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      check_q <= 1'b1;
    end else if (in_fire) begin
      if (last) begin
        cnt_q   <= '0;
        check_q <= 1'b1;
      end else begin
        cnt_q   <= cnt_q + CNT_W'(1);
        check_q <= check_eff;
      end
    end
  end

  // ---------------------------------------------------- head shift line
  // after six shifts the cell at the far end holds byte 0
  for (genvar k = 0; k < HEAD_LEN; k++) begin : g_head
    rcfd_byte_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (in_fire && (cnt_q < CNT_W'(HEAD_LEN))),
      .byte_i  ((k == 0) ? in_i.rx_byte : head[(k == 0) ? 0 : k-1]),
      .byte_o  (head[k])
    );
  end

  // b[n] = head[5-n]
  assign chan[0] = {head[4][2:0], head[5]};
  assign chan[1] = {head[3][5:0], head[4][7:3]};
  assign chan[2] = {head[1][0], head[2], head[3][7:6]};
  assign chan[3] = {head[0][3:0], head[1][7:1]};

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    rcfd_chan_cell u_chan (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .chan_i      (chan[c]),
      .cfg_i       (cfg_q),
      .held_next_o (held_next[c])
    );
  end

  // ------------------------------------------------- switches and gates
  always_comb begin
    sw_one_d = sw_one_q;
    sw_two_d = sw_two_q;
    gates_d  = gates_q;
    if (load) begin
      sw_one_d = head[0][7:6];
      sw_two_d = head[0][5:4];
      gates_d  = gates_for(head[0][7:6]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_one_q <= '0;
      sw_two_q <= '0;
      gates_q  <= '0;
    end else begin
      sw_one_q <= sw_one_d;
      sw_two_q <= sw_two_d;
      gates_q  <= gates_d;
    end
  end

  // -------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last) begin
      out_o.frame_valid  <= check_eff;
      out_o.stick_x      <= held_next[0];
      out_o.stick_y      <= held_next[1];
      out_o.rotation     <= held_next[2];
      out_o.pitch_offset <= held_next[3];
      out_o.switch_one   <= sw_one_d;
      out_o.switch_two   <= sw_two_d;
      out_o.gate_a       <= gates_d.gate_a;
      out_o.gate_b       <= gates_d.gate_b;
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_IDX)
    else $error("byte count past frame end");

  a_last_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last |=> out_valid_q && cnt_q == '0 && check_q)
    else $error("frame end did not produce a result word");

  a_mid_frame_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !last |=> $stable(sw_one_q) && $stable(gates_q))
    else $error("held switches changed inside a frame");

  a_bad_frame_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last && !check_eff |=> $stable(sw_two_q) && !out_o.frame_valid)
    else $error("invalid frame changed held values");
`endif

endmodule

// ----- rtl/rcfd_byte_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_byte_cell
// One stage of the frame head shift line; takes its neighbor's byte on shift.
// ----------------------------------------------------------------------------
module rcfd_byte_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// ----- rtl/rcfd_chan_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_chan_cell
// One channel lane: window check, center offset and the held offset.
// ----------------------------------------------------------------------------
module rcfd_chan_cell
  import rcfd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic [CHAN_W-1:0]       chan_i,
  input  cfg_t                    cfg_i,
  output logic signed [OFS_W-1:0] held_next_o
);

  logic signed [OFS_W-1:0] held_q, held_d;
  logic                    in_window;
  logic signed [OFS_W-1:0] offset;

  assign in_window = (chan_i > cfg_i.window_low) && (chan_i < cfg_i.window_high);
  assign offset    = $signed({1'b0, chan_i} - {1'b0, cfg_i.center_value});

  always_comb begin
    held_d = held_q;
    if (load_i && in_window) begin
      held_d = offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  assign held_next_o = held_d;

endmodule

// ----- tb/tb_rc_frame_channel_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_frame_channel_decoder
// Streams whole 17-byte frames into the decoder. Some frames pass the zero
// check and some break it. The held channel offsets, switches and gate values
// are predicted for each frame end and compared with every result word. The
// window and center registers are swept across several settings, the
// extremes and an inverted window among them. Sender gaps and receiver stalls
// vary by phase.
// ----------------------------------------------------------------------------
module tb_rc_frame_channel_decoder;
  import rcfd_pkg::*;

  localparam int FRAME_LEN   = 17;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYC  = 3;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic              frame_valid;
    logic signed [11:0] stick_x;
    logic signed [11:0] stick_y;
    logic signed [11:0] rotation;
    logic signed [11:0] pitch_offset;
    logic [1:0]        switch_one;
    logic [1:0]        switch_two;
    logic [6:0]        gate_a;
    logic [6:0]        gate_b;
  } frame_result_t;

  logic clk;
  logic rst_n;

  rcfd_byte_if   in_if();
  rcfd_result_if out_if();
  rcfd_cfg_if    cfg_if();

  rc_frame_channel_decoder #(
    .FRAME_LEN(FRAME_LEN)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // decoder state as predicted from the accepted bytes
  cfg_t              dec_cfg;
  logic [4:0]        dec_count;
  logic [7:0]        dec_head[HEAD_LEN];
  logic              dec_zero_ok;
  logic signed [11:0] dec_offs[NUM_CHAN];
  logic [1:0]        dec_sw1;
  logic [1:0]        dec_sw2;
  logic [6:0]        dec_gate_a;
  logic [6:0]        dec_gate_b;

  frame_result_t expected_frames[$];
  frame_result_t want;

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int mismatch_count;
  int results_seen;
  int frames_sent;
  int good_frames;
  int cfg_phases;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still pending", cycle_count,
               expected_frames.size());
      $display("rc_frame_channel_decoder: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [11:0] got,
                             input logic [11:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("result %0d %s: got 0x%03h want 0x%03h",
                                results_seen, name, got, exp_val));
    end
  endtask

  // result side: compare each accepted word, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        report_mismatch("result word with no frame pending");
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_valid", 12'(out_if.frame_valid), 12'(want.frame_valid));
        check_field("stick_x", out_if.stick_x, want.stick_x);
        check_field("stick_y", out_if.stick_y, want.stick_y);
        check_field("rotation", out_if.rotation, want.rotation);
        check_field("pitch_offset", out_if.pitch_offset, want.pitch_offset);
        check_field("switch_one", 12'(out_if.switch_one), 12'(want.switch_one));
        check_field("switch_two", 12'(out_if.switch_two), 12'(want.switch_two));
        check_field("gate_a", 12'(out_if.gate_a), 12'(want.gate_a));
        check_field("gate_b", 12'(out_if.gate_b), 12'(want.gate_b));
      end
    end
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic clear_decoder_state();
    dec_cfg.window_low   = WINDOW_LOW_RST;
    dec_cfg.window_high  = WINDOW_HIGH_RST;
    dec_cfg.center_value = CENTER_VALUE_RST;
    dec_count   = '0;
    dec_zero_ok = 1'b1;
    dec_sw1     = '0;
    dec_sw2     = '0;
    dec_gate_a  = '0;
    dec_gate_b  = '0;
    for (int i = 0; i < HEAD_LEN; i++) dec_head[i] = '0;
    for (int i = 0; i < NUM_CHAN; i++) dec_offs[i] = '0;
  endtask

  // advance the frame decode by one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    logic [47:0]   head;
    logic [10:0]   chan;
    frame_result_t r;
    if (dec_count < HEAD_LEN) begin
      dec_head[dec_count] = b;
    end else if (dec_count < CHECK_END && b != 8'd0) begin
      dec_zero_ok = 1'b0;
    end
    if (dec_count + 1 < FRAME_LEN) begin
      dec_count = dec_count + 5'd1;
    end else begin
      if (dec_zero_ok) begin
        good_frames++;
        head = {dec_head[5], dec_head[4], dec_head[3],
                dec_head[2], dec_head[1], dec_head[0]};
        for (int i = 0; i < NUM_CHAN; i++) begin
          chan = head[i*CHAN_W +: CHAN_W];
          if (chan > dec_cfg.window_low && chan < dec_cfg.window_high) begin
            dec_offs[i] = {1'b0, chan} - {1'b0, dec_cfg.center_value};
          end
        end
        dec_sw1 = head[47:46];
        dec_sw2 = head[45:44];
        case (dec_sw1)
          SW_MODE_LOW: begin
            dec_gate_a = GATE_A_ON;
            dec_gate_b = GATE_B_LOW;
          end
          SW_MODE_HIGH: begin
            dec_gate_a = GATE_A_ON;
            dec_gate_b = GATE_B_HIGH;
          end
          default: begin
            dec_gate_a = GATE_A_OFF;
            dec_gate_b = GATE_B_OFF;
          end
        endcase
      end
      r.frame_valid  = dec_zero_ok;
      r.stick_x      = dec_offs[0];
      r.stick_y      = dec_offs[1];
      r.rotation     = dec_offs[2];
      r.pitch_offset = dec_offs[3];
      r.switch_one   = dec_sw1;
      r.switch_two   = dec_sw2;
      r.gate_a       = dec_gate_a;
      r.gate_b       = dec_gate_b;
      expected_frames.push_back(r);
      dec_count   = '0;
      dec_zero_ok = 1'b1;
    end
  endtask

  // valid stays high after a word so back-to-back bytes need no second edit
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    decode_byte(b);
  endtask

  task automatic send_frame(input logic [10:0] c0, input logic [10:0] c1,
                            input logic [10:0] c2, input logic [10:0] c3,
                            input logic [1:0] sw1, input logic [1:0] sw2,
                            input logic [5:0] dirty_mask);
    logic [47:0] head;
    head = {sw1, sw2, c3, c2, c1, c0};
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i < HEAD_LEN) begin
        send_byte(head[i*8 +: 8]);
      end else if (i < CHECK_END) begin
        send_byte(dirty_mask[i-HEAD_LEN] ? 8'($urandom_range(1, 255)) : 8'd0);
      end else begin
        send_byte(8'($urandom));
      end
    end
    frames_sent++;
  endtask

  // stop sending and let every pending result word drain out
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [10:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_WINDOW_LOW:   dec_cfg.window_low = val;
      REG_WINDOW_HIGH:  dec_cfg.window_high = val;
      REG_CENTER_VALUE: dec_cfg.center_value = val;
      default: ;
    endcase
  endtask

  task automatic write_window(input logic [10:0] lo, input logic [10:0] hi,
                              input logic [10:0] ctr);
    write_reg(REG_WINDOW_LOW, lo);
    write_reg(REG_WINDOW_HIGH, hi);
    write_reg(REG_CENTER_VALUE, ctr);
    cfg_if.valid <= 1'b0;
    cfg_phases++;
  endtask

  // half the values right at the window bounds, the rest anywhere
  function automatic logic [10:0] pick_channel();
    logic [10:0] ch;
    case ($urandom_range(3))
      0: ch = dec_cfg.window_low + 11'($urandom_range(2)) - 11'd1;
      1: ch = dec_cfg.window_high + 11'($urandom_range(2)) - 11'd1;
      default: ch = 11'($urandom);
    endcase
    return ch;
  endfunction

  task automatic run_traffic(input int idle_pct, input int stall_pct,
                             input logic [10:0] lo, input logic [10:0] hi,
                             input logic [10:0] ctr, input int n_frames);
    logic [5:0] dirty;
    settle();
    write_window(lo, hi, ctr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int f = 0; f < n_frames; f++) begin
      // hold off mid-phase until the receiver has caught up
      if (f == n_frames / 2) settle();
      dirty = ($urandom_range(99) < 25) ? 6'($urandom_range(1, 63)) : 6'd0;
      send_frame(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                 2'($urandom), 2'($urandom), dirty);
    end
  endtask

  // all-ones frame fails the check before anything was held: zeros come out
  task automatic test_power_on_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < FRAME_LEN; i++) send_byte(8'hFF);
    frames_sent++;
  endtask

  // channels one inside and exactly on each bound of the reset window
  task automatic test_window_edges();
    send_frame(WINDOW_LOW_RST + 11'd1, WINDOW_HIGH_RST - 11'd1, WINDOW_LOW_RST,
               WINDOW_HIGH_RST, SW_MODE_HIGH, 2'd2, 6'd0);
  endtask

  task automatic test_reset_window_stream();
    run_traffic(0, 0, WINDOW_LOW_RST, WINDOW_HIGH_RST, CENTER_VALUE_RST, 20);
  endtask

  task automatic test_open_window_zero_center();
    run_traffic(84, 0, 11'd0, 11'd2047, 11'd0, 20);
  endtask

  task automatic test_open_window_top_center();
    run_traffic(0, 84, 11'd0, 11'd2047, 11'd2047, 20);
  endtask

  task automatic test_inverted_window();
    run_traffic(34, 34, 11'd2047, 11'd0, 11'd1024, 10);
  endtask

  task automatic test_random_windows();
    for (int p = 0; p < 3; p++) begin
      run_traffic((p == 1) ? 34 : 84 * (p / 2), (p == 1) ? 34 : 0,
                  11'($urandom_range(0, 1023)), 11'($urandom_range(1024, 2047)),
                  11'($urandom), 10);
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.rx_byte  = '0;
    out_if.ready   = 1'b1;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_WINDOW_LOW;
    cfg_if.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    mismatch_count = 0;
    results_seen   = 0;
    frames_sent    = 0;
    good_frames    = 0;
    cfg_phases     = 0;
    clear_decoder_state();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_hold();
    test_window_edges();
    test_reset_window_stream();
    test_open_window_zero_center();
    test_open_window_top_center();
    test_inverted_window();
    test_random_windows();

    settle();
    $display("covered %0d frames (%0d passing the zero check) over %0d register settings",
             frames_sent, good_frames, cfg_phases);
    $display("checked %0d result words under gaps and stalls of 0, 34 and 84 percent",
             results_seen);
    if (mismatch_count == 0) begin
      $display("rc_frame_channel_decoder: match");
    end else begin
      $display("rc_frame_channel_decoder: mismatch");
    end
    $finish;
  end

endmodule
